// ===== rtl/core/pic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

    localparam int NUM_LINES = 64;
    localparam int MAX_PRIO  = 15;

    localparam int LINE_W    = 6;
    localparam int CMD_W     = 3;
    localparam int PRIO_IN_W = 8;
    localparam int VENDOR_W  = 16;
    localparam int STATUS_W  = 2;

    localparam int IDX_W  = $clog2(NUM_LINES);
    localparam int CNT_W  = $clog2(NUM_LINES + 1);
    localparam int PRIO_W = $clog2(MAX_PRIO + 1);

    localparam logic [VENDOR_W-1:0] SPECIAL_VENDOR = 16'h1004;
    localparam logic [PRIO_W-1:0]   FORCED_PRIO    = PRIO_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE     = 3'd0,
        CMD_DISABLE  = 3'd1,
        CMD_ENABLE   = 3'd2,
        CMD_IGNORE   = 3'd3,
        CMD_UNIGNORE = 3'd4,
        CMD_COMPLETE = 3'd5,
        CMD_SET_PRIO = 3'd6,
        CMD_CLAIM    = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_BADPRIO = 2'd2,
        STAT_DROPPED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        LS_IDLE    = 2'd0,
        LS_PENDING = 2'd1,
        LS_SERVICE = 2'd2
    } line_st_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_READ,
        CS_MODIFY,
        CS_SCAN,
        CS_SCAN_TAIL,
        CS_GRANT,
        CS_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic              enabled;
        logic              ignored;
        line_st_t          state;
        logic [PRIO_W-1:0] prio;
    } line_rec_t;

    localparam line_rec_t REC_RESET = '{
        enabled: 1'b0,
        ignored: 1'b0,
        state:   LS_IDLE,
        prio:    PRIO_W'(MAX_PRIO)
    };

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        line_rec_t        wr_data;
    } mem_req_t;

    typedef struct packed {
        logic             clear;
        logic             cmp_en;
        logic [IDX_W-1:0] idx;
    } scan_ctl_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        line_rec_t        rec;
    } scan_res_t;

    function automatic logic line_in_range(input logic [LINE_W-1:0] line);
        return {1'b0, line} < (LINE_W + 1)'(NUM_LINES);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pic_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pic_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [pic_pkg::CMD_W-1:0]     command_code;
    logic [pic_pkg::LINE_W-1:0]    irq_line;
    logic [pic_pkg::PRIO_IN_W-1:0] priority_value;
    logic [pic_pkg::VENDOR_W-1:0]  maker_id;

    modport source (
        output valid, req_type, command_code, irq_line, priority_value, maker_id,
        input  ready
    );
    modport sink (
        input  valid, req_type, command_code, irq_line, priority_value, maker_id,
        output ready
    );
endinterface

interface pic_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pic_pkg::STATUS_W-1:0] status_code;
    logic [pic_pkg::LINE_W-1:0]   granted_line;
    logic                         irq_out;

    modport source (
        output valid, status_code, granted_line, irq_out,
        input  ready
    );
    modport sink (
        input  valid, status_code, granted_line, irq_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/pic_line_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pic_line_mem (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pic_pkg::mem_req_t  mem_req,
    output pic_pkg::line_rec_t      rd_rec
);

    pic_pkg::line_rec_t                  mem [pic_pkg::NUM_LINES];
    pic_pkg::line_rec_t                  rd_data_reg;
    logic [pic_pkg::NUM_LINES-1:0]       written_reg;
    logic                                rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        rd_data_reg <= mem[mem_req.rd_addr];
    end

    // entries never written read back as the reset record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (mem_req.wr_en)
            begin
                written_reg[mem_req.wr_addr] <= 1'b1;
            end
            rd_written_reg <= written_reg[mem_req.rd_addr];
        end
    end

    assign rd_rec = rd_written_reg ? rd_data_reg : pic_pkg::REC_RESET;

endmodule

`default_nettype wire

// ===== rtl/core/pic_claim_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pic_claim_scan (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pic_pkg::scan_ctl_t  scan_ctl,
    input  wire pic_pkg::line_rec_t  rd_rec,
    output pic_pkg::scan_res_t       scan_res
);

    logic [pic_pkg::PRIO_W-1:0] best_prio_reg;
    logic                       found_reg;
    logic [pic_pkg::IDX_W-1:0]  best_idx_reg;
    pic_pkg::line_rec_t         best_rec_reg;
    logic                       hit;

    // strict less-than keeps the lower index on ties
    assign hit = scan_ctl.cmp_en && rd_rec.enabled && !rd_rec.ignored &&
                 (rd_rec.state == pic_pkg::LS_PENDING) && (rd_rec.prio < best_prio_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_prio_reg <= pic_pkg::PRIO_W'(pic_pkg::MAX_PRIO);
            found_reg     <= 1'b0;
        end
        else if (scan_ctl.clear)
        begin
            best_prio_reg <= pic_pkg::PRIO_W'(pic_pkg::MAX_PRIO);
            found_reg     <= 1'b0;
        end
        else if (hit)
        begin
            best_prio_reg <= rd_rec.prio;
            found_reg     <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            best_idx_reg <= scan_ctl.idx;
            best_rec_reg <= rd_rec;
        end
    end

    assign scan_res = '{found: found_reg, idx: best_idx_reg, rec: best_rec_reg};

endmodule

`default_nettype wire

// ===== rtl/core/pic_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pic_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    pic_req_if.sink                  req,
    pic_rsp_if.source                rsp,
    output pic_pkg::mem_req_t        mem_req,
    input  wire pic_pkg::line_rec_t  rd_rec,
    output pic_pkg::scan_ctl_t       scan_ctl,
    input  wire pic_pkg::scan_res_t  scan_res
);

    pic_pkg::ctrl_state_t state_reg, state_next;

    logic                            req_type_reg;
    pic_pkg::cmd_t                   req_cmd_reg;
    logic [pic_pkg::LINE_W-1:0]      req_line_reg;
    logic [pic_pkg::PRIO_W-1:0]      req_prio_reg;
    logic [pic_pkg::VENDOR_W-1:0]    req_vendor_reg;

    logic [pic_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            cmp_en_reg, cmp_en_next;
    logic [pic_pkg::IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    pic_pkg::status_t                status_reg, status_next;
    logic [pic_pkg::LINE_W-1:0]      granted_reg, granted_next;
    logic [pic_pkg::NUM_LINES-1:0]   valid_reg, valid_next;

    logic                            out_valid_reg, out_valid_next;
    pic_pkg::status_t                out_status_reg;
    logic [pic_pkg::LINE_W-1:0]      out_granted_reg;
    logic                            out_irq_reg;

    logic                            accept;
    logic                            load_out;
    logic [pic_pkg::IDX_W-1:0]       line_idx;
    logic [pic_pkg::NUM_LINES-1:0]   line_mask;
    pic_pkg::cmd_t                   in_cmd;
    pic_pkg::line_rec_t              new_rec;

    assign in_cmd    = pic_pkg::cmd_t'(req.command_code);
    assign line_idx  = req_line_reg[pic_pkg::IDX_W-1:0];
    assign line_mask = pic_pkg::NUM_LINES'(1) << line_idx;
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pic_pkg::CS_IDLE;
            cnt_reg       <= '0;
            cmp_en_reg    <= 1'b0;
            status_reg    <= pic_pkg::STAT_OK;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmp_en_reg    <= cmp_en_next;
            status_reg    <= status_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg   <= req.req_type;
            req_cmd_reg    <= in_cmd;
            req_line_reg   <= req.irq_line;
            req_prio_reg   <= req.priority_value[pic_pkg::PRIO_W-1:0];
            req_vendor_reg <= req.maker_id;
        end
        cmp_idx_reg <= cmp_idx_next;
        granted_reg <= granted_next;
        if (load_out)
        begin
            out_status_reg  <= status_reg;
            out_granted_reg <= granted_reg;
            out_irq_reg     <= |valid_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmp_en_next  = 1'b0;
        cmp_idx_next = cnt_reg[pic_pkg::IDX_W-1:0];
        status_next  = status_reg;
        granted_next = granted_reg;
        valid_next   = valid_reg;
        new_rec      = rd_rec;
        load_out     = 1'b0;
        req.ready    = 1'b0;
        mem_req      = '{rd_addr: line_idx, wr_en: 1'b0, wr_addr: line_idx, wr_data: rd_rec};
        scan_ctl     = '{clear: 1'b0, cmp_en: cmp_en_reg, idx: cmp_idx_reg};

        case (state_reg)
            pic_pkg::CS_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    status_next  = pic_pkg::STAT_OK;
                    granted_next = '0;
                    state_next   = pic_pkg::CS_DONE;
                    if (!req.req_type)
                    begin
                        if (pic_pkg::line_in_range(req.irq_line))
                        begin
                            state_next = pic_pkg::CS_READ;
                        end
                        else
                        begin
                            status_next = pic_pkg::STAT_DROPPED;
                        end
                    end
                    else
                    begin
                        case (in_cmd)
                            pic_pkg::CMD_NONE:
                            begin
                                state_next = pic_pkg::CS_DONE;
                            end
                            pic_pkg::CMD_CLAIM:
                            begin
                                scan_ctl.clear = 1'b1;
                                cnt_next       = '0;
                                state_next     = pic_pkg::CS_SCAN;
                            end
                            pic_pkg::CMD_SET_PRIO:
                            begin
                                if (req.priority_value >= pic_pkg::PRIO_IN_W'(pic_pkg::MAX_PRIO))
                                begin
                                    status_next = pic_pkg::STAT_BADPRIO;
                                end
                                else if (pic_pkg::line_in_range(req.irq_line))
                                begin
                                    state_next = pic_pkg::CS_READ;
                                end
                            end
                            default:
                            begin
                                if (pic_pkg::line_in_range(req.irq_line))
                                begin
                                    state_next = pic_pkg::CS_READ;
                                end
                            end
                        endcase
                    end
                end
            end

            pic_pkg::CS_READ:
            begin
                state_next = pic_pkg::CS_MODIFY;
            end

            pic_pkg::CS_MODIFY:
            begin
                state_next     = pic_pkg::CS_DONE;
                mem_req.wr_en  = 1'b1;
                if (!req_type_reg)
                begin
                    if (!rd_rec.enabled)
                    begin
                        status_next   = pic_pkg::STAT_DROPPED;
                        mem_req.wr_en = 1'b0;
                    end
                    else
                    begin
                        new_rec.state = pic_pkg::LS_PENDING;
                        if (req_vendor_reg == pic_pkg::SPECIAL_VENDOR)
                        begin
                            new_rec.prio = pic_pkg::FORCED_PRIO;
                        end
                        valid_next = valid_reg | line_mask;
                    end
                end
                else
                begin
                    case (req_cmd_reg)
                        pic_pkg::CMD_DISABLE:
                        begin
                            new_rec.enabled = 1'b0;
                            valid_next      = valid_reg & ~line_mask;
                        end
                        pic_pkg::CMD_ENABLE:
                        begin
                            new_rec.enabled = 1'b1;
                            if (!rd_rec.ignored && rd_rec.state == pic_pkg::LS_PENDING)
                            begin
                                valid_next = valid_reg | line_mask;
                            end
                        end
                        pic_pkg::CMD_IGNORE:
                        begin
                            new_rec.ignored = 1'b1;
                            valid_next      = valid_reg & ~line_mask;
                        end
                        pic_pkg::CMD_UNIGNORE:
                        begin
                            new_rec.ignored = 1'b0;
                            if (rd_rec.enabled && rd_rec.state == pic_pkg::LS_PENDING)
                            begin
                                valid_next = valid_reg | line_mask;
                            end
                        end
                        pic_pkg::CMD_COMPLETE:
                        begin
                            new_rec.state = pic_pkg::LS_IDLE;
                            valid_next    = valid_reg & ~line_mask;
                        end
                        pic_pkg::CMD_SET_PRIO:
                        begin
                            new_rec.prio = req_prio_reg;
                        end
                        default:
                        begin
                            mem_req.wr_en = 1'b0;
                        end
                    endcase
                end
                mem_req.wr_data = new_rec;
            end

            pic_pkg::CS_SCAN:
            begin
                // one line read per cycle; each compare runs in the cycle after its read
                mem_req.rd_addr = cnt_reg[pic_pkg::IDX_W-1:0];
                cmp_en_next     = 1'b1;
                cnt_next        = cnt_reg + pic_pkg::CNT_W'(1);
                if (cnt_reg == pic_pkg::CNT_W'(pic_pkg::NUM_LINES - 1))
                begin
                    state_next = pic_pkg::CS_SCAN_TAIL;
                end
            end

            pic_pkg::CS_SCAN_TAIL:
            begin
                state_next = pic_pkg::CS_GRANT;
            end

            pic_pkg::CS_GRANT:
            begin
                state_next = pic_pkg::CS_DONE;
                if (scan_res.found)
                begin
                    new_rec         = scan_res.rec;
                    new_rec.state   = pic_pkg::LS_SERVICE;
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = scan_res.idx;
                    mem_req.wr_data = new_rec;
                    granted_next    = pic_pkg::LINE_W'(scan_res.idx);
                end
                else
                begin
                    status_next = pic_pkg::STAT_EMPTY;
                end
            end

            pic_pkg::CS_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = pic_pkg::CS_IDLE;
                end
            end

            default:
            begin
                state_next = pic_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status_code  = out_status_reg;
    assign rsp.granted_line = out_granted_reg;
    assign rsp.irq_out      = out_irq_reg;

endmodule

`default_nettype wire

// ===== rtl/core/priority_interrupt_controller_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Priority interrupt controller: one request transaction (device trigger or
// software command) gives one response transaction with a status, the granted
// line of a claim, and the irq flag after the request. Requests are handled one
// at a time: a trigger or a line command on a valid line is a read-modify-write
// of the line table in the read and modify states before the done state; command
// none or a rejected priority goes from idle straight to the done state;
// a claim reads the table one line per cycle through a single comparator in the
// scan state, then passes the scan tail and grant states.
// A finished response waits in an output register, so a new request is taken
// while the previous response has not been collected yet; while that register
// still holds an uncollected response, the next one waits in the last cycle.
// The line table needs no clearing pass after reset.
module priority_interrupt_controller_top (
    input  wire logic clk,
    input  wire logic rst_n,
    pic_req_if.sink   req,
    pic_rsp_if.source rsp
);

    pic_pkg::mem_req_t  mem_req;
    pic_pkg::line_rec_t rd_rec;
    pic_pkg::scan_ctl_t scan_ctl;
    pic_pkg::scan_res_t scan_res;

    pic_line_mem u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .rd_rec  (rd_rec)
    );

    pic_claim_scan u_claim_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .scan_ctl (scan_ctl),
        .rd_rec   (rd_rec),
        .scan_res (scan_res)
    );

    pic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .mem_req  (mem_req),
        .rd_rec   (rd_rec),
        .scan_ctl (scan_ctl),
        .scan_res (scan_res)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while previous one still in progress");

    a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.granted_line != '0 |-> rsp.status_code == pic_pkg::STAT_OK)
        else $error("nonzero granted line with failing status");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> !scan_ctl.cmp_en)
        else $error("line table written during claim scan");

    a_found_prio_legal: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.found |-> scan_res.rec.prio < pic_pkg::PRIO_W'(pic_pkg::MAX_PRIO))
        else $error("claim candidate with priority at or above maximum");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_priority_interrupt_controller_top.sv =====
`timescale 1ns / 1ps

module tb_priority_interrupt_controller_top;

    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic                          req_type;
        pic_pkg::cmd_t                 cmd;
        logic [pic_pkg::LINE_W-1:0]    line;
        logic [pic_pkg::PRIO_IN_W-1:0] prio_val;
        logic [pic_pkg::VENDOR_W-1:0]  vendor;
    } irq_req_t;

    typedef struct {
        logic [pic_pkg::STATUS_W-1:0] status;
        logic [pic_pkg::LINE_W-1:0]   granted;
        logic                         irq;
    } irq_rsp_t;

    // Line table mirror plus the queue of responses still owed by the block.
    class irq_tracker;
        bit                         enabled[pic_pkg::NUM_LINES];
        bit                         ignored[pic_pkg::NUM_LINES];
        pic_pkg::line_st_t          state[pic_pkg::NUM_LINES];
        logic [pic_pkg::PRIO_W-1:0] prio[pic_pkg::NUM_LINES];
        logic [pic_pkg::NUM_LINES-1:0] valid_bits;
        irq_rsp_t                   owed_rsp[$];
        int                         errors;

        function new();
            for (int i = 0; i < pic_pkg::NUM_LINES; i++)
            begin
                enabled[i] = 1'b0;
                ignored[i] = 1'b0;
                state[i]   = pic_pkg::LS_IDLE;
                prio[i]    = pic_pkg::PRIO_W'(pic_pkg::MAX_PRIO);
            end
            valid_bits = '0;
            errors     = 0;
        endfunction

        function void refresh_line(int n);
            if (enabled[n] && !ignored[n] && state[n] == pic_pkg::LS_PENDING)
                valid_bits[n] = 1'b1;
        endfunction

        function void note_request(irq_req_t t);
            irq_rsp_t r;
            int       n;
            int       best;
            r.status  = pic_pkg::STAT_OK;
            r.granted = '0;
            n = int'(t.line);
            if (t.req_type == 1'b0)
            begin
                if (!enabled[n])
                    r.status = pic_pkg::STAT_DROPPED;
                else
                begin
                    if (t.vendor == pic_pkg::SPECIAL_VENDOR)
                        prio[n] = pic_pkg::FORCED_PRIO;
                    state[n]      = pic_pkg::LS_PENDING;
                    valid_bits[n] = 1'b1;
                end
            end
            else
            begin
                case (t.cmd)
                    pic_pkg::CMD_DISABLE:
                    begin
                        enabled[n]    = 1'b0;
                        valid_bits[n] = 1'b0;
                    end
                    pic_pkg::CMD_ENABLE:
                    begin
                        enabled[n] = 1'b1;
                        refresh_line(n);
                    end
                    pic_pkg::CMD_IGNORE:
                    begin
                        ignored[n]    = 1'b1;
                        valid_bits[n] = 1'b0;
                    end
                    pic_pkg::CMD_UNIGNORE:
                    begin
                        ignored[n] = 1'b0;
                        refresh_line(n);
                    end
                    pic_pkg::CMD_COMPLETE:
                    begin
                        state[n]      = pic_pkg::LS_IDLE;
                        valid_bits[n] = 1'b0;
                    end
                    pic_pkg::CMD_SET_PRIO:
                    begin
                        if (int'(t.prio_val) >= pic_pkg::MAX_PRIO)
                            r.status = pic_pkg::STAT_BADPRIO;
                        else
                            prio[n] = t.prio_val[pic_pkg::PRIO_W-1:0];
                    end
                    pic_pkg::CMD_CLAIM:
                    begin
                        best = pic_pkg::MAX_PRIO;
                        r.status = pic_pkg::STAT_EMPTY;
                        for (int i = 0; i < pic_pkg::NUM_LINES; i++)
                        begin
                            if (int'(prio[i]) < best && enabled[i] && !ignored[i]
                                && state[i] == pic_pkg::LS_PENDING)
                            begin
                                best      = int'(prio[i]);
                                r.granted = pic_pkg::LINE_W'(i);
                                r.status  = pic_pkg::STAT_OK;
                            end
                        end
                        if (r.status == pic_pkg::STAT_OK)
                            state[r.granted] = pic_pkg::LS_SERVICE;
                    end
                    default: ;
                endcase
            end
            r.irq = |valid_bits;
            owed_rsp.push_back(r);
        endfunction

        function void check_response(irq_rsp_t got);
            irq_rsp_t want;
            if (owed_rsp.size() == 0)
            begin
                $error("response with none outstanding: status=%0d granted=%0d irq=%0d",
                       got.status, got.granted, got.irq);
                errors++;
                return;
            end
            want = owed_rsp.pop_front();
            if (got.status !== want.status)
            begin
                $error("status_code: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.granted !== want.granted)
            begin
                $error("granted_line: expected %0d, actual %0d", want.granted, got.granted);
                errors++;
            end
            if (got.irq !== want.irq)
            begin
                $error("irq_out: expected %0d, actual %0d", want.irq, got.irq);
                errors++;
            end
        endfunction

        function int outstanding();
            return owed_rsp.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pic_req_if req_ch();
    pic_rsp_if rsp_ch();

    priority_interrupt_controller_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    irq_tracker book;
    bit         calm;
    int         idle_pct;
    int         hot_lines[6];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic irq_req_t make_req(logic rt, pic_pkg::cmd_t cmd, int line, int pv,
                                          int vid);
        irq_req_t t;
        t.req_type = rt;
        t.cmd      = cmd;
        t.line     = pic_pkg::LINE_W'(line);
        t.prio_val = pic_pkg::PRIO_IN_W'(pv);
        t.vendor   = pic_pkg::VENDOR_W'(vid);
        return t;
    endfunction

    function automatic irq_req_t trig(int line, int vid);
        return make_req(1'b0, pic_pkg::cmd_t'($urandom_range(0, 7)), line,
                        $urandom_range(0, 255), vid);
    endfunction

    function automatic irq_req_t cmd(pic_pkg::cmd_t c, int line, int pv);
        return make_req(1'b1, c, line, pv, $urandom_range(0, 65535));
    endfunction

    function automatic irq_req_t random_req();
        int            roll;
        int            line;
        int            pv;
        int            vid;
        pic_pkg::cmd_t c;
        if ($urandom_range(0, 99) < 75)
            line = hot_lines[$urandom_range(0, 5)];
        else
            line = $urandom_range(0, pic_pkg::NUM_LINES - 1);
        pv  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, pic_pkg::MAX_PRIO - 1)
                                         : $urandom_range(0, 255);
        vid = ($urandom_range(0, 3) == 0) ? int'(pic_pkg::SPECIAL_VENDOR)
                                          : $urandom_range(0, 65535);
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return make_req(1'b0, pic_pkg::cmd_t'($urandom_range(0, 7)), line, pv, vid);
        if (roll < 47)      c = pic_pkg::CMD_ENABLE;
        else if (roll < 52) c = pic_pkg::CMD_DISABLE;
        else if (roll < 57) c = pic_pkg::CMD_IGNORE;
        else if (roll < 62) c = pic_pkg::CMD_UNIGNORE;
        else if (roll < 70) c = pic_pkg::CMD_COMPLETE;
        else if (roll < 79) c = pic_pkg::CMD_SET_PRIO;
        else if (roll < 97) c = pic_pkg::CMD_CLAIM;
        else                c = pic_pkg::CMD_NONE;
        return make_req(1'b1, c, line, pv, vid);
    endfunction

    task automatic send_req(input irq_req_t t);
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= t.req_type;
        req_ch.command_code   <= t.cmd;
        req_ch.irq_line       <= t.line;
        req_ch.priority_value <= t.prio_val;
        req_ch.maker_id       <= t.vendor;
        do
            @(posedge clk);
        while (!req_ch.ready);
        book.note_request(t);
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // response side: random stall bursts, checks each accepted transaction
    initial
    begin
        int       stall_left;
        irq_rsp_t got;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status  = rsp_ch.status_code;
                got.granted = rsp_ch.granted_line;
                got.irq     = rsp_ch.irq_out;
                book.check_response(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rst_n && !calm && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        irq_req_t directed[$];
        book     = new();
        calm     = 1'b0;
        idle_pct = 10;
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= 1'b0;
        req_ch.command_code   <= pic_pkg::CMD_NONE;
        req_ch.irq_line       <= '0;
        req_ch.priority_value <= '0;
        req_ch.maker_id       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(cmd(pic_pkg::CMD_CLAIM, 0, 0));        // empty table
        directed.push_back(trig(0, 0));                           // disabled line
        directed.push_back(cmd(pic_pkg::CMD_NONE, 63, 255));
        directed.push_back(cmd(pic_pkg::CMD_ENABLE, 0, 0));
        directed.push_back(cmd(pic_pkg::CMD_ENABLE, 63, 0));
        directed.push_back(cmd(pic_pkg::CMD_ENABLE, 10, 0));
        directed.push_back(trig(10, 16'hFFFF));
        directed.push_back(cmd(pic_pkg::CMD_CLAIM, 0, 0));        // prio at MAX never granted
        directed.push_back(cmd(pic_pkg::CMD_SET_PRIO, 0, pic_pkg::MAX_PRIO));
        directed.push_back(cmd(pic_pkg::CMD_SET_PRIO, 0, 255));
        directed.push_back(cmd(pic_pkg::CMD_SET_PRIO, 0, 0));
        directed.push_back(trig(63, pic_pkg::SPECIAL_VENDOR));
        directed.push_back(cmd(pic_pkg::CMD_IGNORE, 63, 0));
        directed.push_back(trig(63, pic_pkg::SPECIAL_VENDOR));    // ignored, still pends
        directed.push_back(trig(0, 16'h1003));
        directed.push_back(cmd(pic_pkg::CMD_CLAIM, 0, 0));
        directed.push_back(cmd(pic_pkg::CMD_UNIGNORE, 63, 0));
        directed.push_back(cmd(pic_pkg::CMD_CLAIM, 0, 0));
        directed.push_back(cmd(pic_pkg::CMD_SET_PRIO, 10, pic_pkg::MAX_PRIO - 1));
        directed.push_back(cmd(pic_pkg::CMD_DISABLE, 10, 0));
        directed.push_back(cmd(pic_pkg::CMD_ENABLE, 10, 0));      // re-enable restores valid
        directed.push_back(cmd(pic_pkg::CMD_CLAIM, 63, 0));
        directed.push_back(cmd(pic_pkg::CMD_COMPLETE, 0, 0));
        directed.push_back(cmd(pic_pkg::CMD_COMPLETE, 63, 0));
        directed.push_back(cmd(pic_pkg::CMD_COMPLETE, 10, 0));
        foreach (directed[i])
            send_req(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                foreach (hot_lines[k])
                    hot_lines[k] = $urandom_range(0, pic_pkg::NUM_LINES - 1);
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 5;
                    default: idle_pct = 25;
                endcase
            end
            if (n >= RANDOM_ITEMS * 85 / 100)
                calm = 1'b1;
            send_req(random_req());
        end
        req_ch.valid <= 1'b0;

        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pic_pkg.sv
rtl/core/pic_ifs.sv
rtl/core/pic_line_mem.sv
rtl/core/pic_claim_scan.sv
rtl/core/pic_ctrl.sv
rtl/core/priority_interrupt_controller_top.sv
bench/tb_priority_interrupt_controller_top.sv
